// File: src/assert_macros.svh
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define SPBPC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define SPBPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/spbpc_pkg.sv
`default_nettype none

package spbpc_pkg;

    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_ANGLE_WIDTH  = 16;
    localparam int POWER_WIDTH      = 48;
    localparam int MAG_WIDTH        = 24;
    localparam int CORDIC_STEPS     = 32;
    localparam int CORDIC_WIDTH     = 64;
    localparam int NORM_MSB         = 60;
    localparam int ACC_WIDTH        = 32;

    // per-request control bits that travel with the data
    typedef struct packed {
        logic valid;
        logic last;
        logic re_neg;
        logic im_neg;
        logic swapped;
        logic zero;
    } flags_t;

    // atan(2^-i), 2^32 counts per full turn
    function automatic logic [ACC_WIDTH-1:0] atan_entry(input logic [4:0] idx);
        logic [ACC_WIDTH-1:0] t;
        unique case (idx)
            5'd0:  t = 32'h2000_0000;
            5'd1:  t = 32'h12E4_051E;
            5'd2:  t = 32'h09FB_385B;
            5'd3:  t = 32'h0511_11D4;
            5'd4:  t = 32'h028B_0D43;
            5'd5:  t = 32'h0145_D7E1;
            5'd6:  t = 32'h00A2_F61E;
            5'd7:  t = 32'h0051_7C55;
            5'd8:  t = 32'h0028_BE53;
            5'd9:  t = 32'h0014_5F2F;
            5'd10: t = 32'h000A_2F98;
            5'd11: t = 32'h0005_17CC;
            5'd12: t = 32'h0002_8BE6;
            5'd13: t = 32'h0001_45F3;
            5'd14: t = 32'h0000_A2FA;
            5'd15: t = 32'h0000_517D;
            5'd16: t = 32'h0000_28BE;
            5'd17: t = 32'h0000_145F;
            5'd18: t = 32'h0000_0A30;
            5'd19: t = 32'h0000_0518;
            5'd20: t = 32'h0000_028C;
            5'd21: t = 32'h0000_0146;
            5'd22: t = 32'h0000_00A3;
            5'd23: t = 32'h0000_0051;
            5'd24: t = 32'h0000_0029;
            5'd25: t = 32'h0000_0014;
            5'd26: t = 32'h0000_000A;
            5'd27: t = 32'h0000_0005;
            5'd28: t = 32'h0000_0003;
            5'd29: t = 32'h0000_0001;
            5'd30: t = 32'h0000_0001;
            5'd31: t = 32'h0000_0000;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: src/spbpc_front.sv
`default_nettype none

module spbpc_front #(
    parameter int SAMPLE_WIDTH = spbpc_pkg::DEF_SAMPLE_WIDTH
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      ce,
    input  wire logic                                      in_valid,
    input  wire logic                                      in_last,
    input  wire logic [SAMPLE_WIDTH-1:0]                   real_part,
    input  wire logic [SAMPLE_WIDTH-1:0]                   imag_part,
    output spbpc_pkg::flags_t                              flags_out,
    output logic signed [spbpc_pkg::CORDIC_WIDTH-1:0]      x_out,
    output logic signed [spbpc_pkg::CORDIC_WIDTH-1:0]      y_out,
    output logic [2*SAMPLE_WIDTH-1:0]                      power_out
);

    localparam int SW  = SAMPLE_WIDTH;
    localparam int PW  = 2 * SAMPLE_WIDTH;
    localparam int CW  = spbpc_pkg::CORDIC_WIDTH;
    localparam int XN  = spbpc_pkg::NORM_MSB + 1;
    localparam int NSH = $clog2(SAMPLE_WIDTH);

    // stage 1: input capture
    spbpc_pkg::flags_t f1_reg, f1_next;
    logic [SW-1:0]     re_reg, im_reg;

    // stage 2: absolute values
    spbpc_pkg::flags_t f2_reg, f2_next;
    logic [SW-1:0]     ar_reg, ar_next, ai_reg, ai_next;

    // stage 3: squares and octant fold
    spbpc_pkg::flags_t f3_reg, f3_next;
    logic [PW-1:0]     sqr_reg, sqr_next, sqi_reg, sqi_next;
    logic [SW-1:0]     mx_reg, mx_next, mn_reg, mn_next;

    // stage 4: power sum and normalization
    spbpc_pkg::flags_t f4_reg;
    logic [PW-1:0]     power_reg, power_next;
    logic [XN-1:0]     nx_reg, nx_next, ny_reg, ny_next;

    always_comb begin
        f1_next       = '0;
        f1_next.valid = in_valid;
        f1_next.last  = in_last;
    end

    // stage 2 logic
    always_comb begin
        f2_next        = f1_reg;
        f2_next.re_neg = re_reg[SW-1];
        f2_next.im_neg = im_reg[SW-1];
        ar_next        = re_reg[SW-1] ? (~re_reg + 1'b1) : re_reg;
        ai_next        = im_reg[SW-1] ? (~im_reg + 1'b1) : im_reg;
    end

    // stage 3 logic
    always_comb begin
        f3_next         = f2_reg;
        f3_next.swapped = ai_reg > ar_reg;
        f3_next.zero    = (ar_reg == '0) && (ai_reg == '0);
        sqr_next        = PW'(ar_reg) * PW'(ar_reg);
        sqi_next        = PW'(ai_reg) * PW'(ai_reg);
        mx_next         = f3_next.swapped ? ai_reg : ar_reg;
        mn_next         = f3_next.swapped ? ar_reg : ai_reg;
    end

    // stage 4 logic: leading-zero shift in halving steps until the msb reaches the top
    always_comb begin
        power_next = sqr_reg + sqi_reg;
        nx_next    = XN'(mx_reg) << (XN - SW);
        ny_next    = XN'(mn_reg) << (XN - SW);
        for (int j = NSH - 1; j >= 0; j--) begin
            if ((nx_next >> (XN - (1 << j))) == '0) begin
                nx_next = nx_next << (1 << j);
                ny_next = ny_next << (1 << j);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg <= '0;
            f2_reg <= '0;
            f3_reg <= '0;
            f4_reg <= '0;
        end else if (ce) begin
            f1_reg <= f1_next;
            f2_reg <= f2_next;
            f3_reg <= f3_next;
            f4_reg <= f3_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (ce) begin
            re_reg    <= real_part;
            im_reg    <= imag_part;
            ar_reg    <= ar_next;
            ai_reg    <= ai_next;
            sqr_reg   <= sqr_next;
            sqi_reg   <= sqi_next;
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;
            power_reg <= power_next;
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
        end
    end

    assign flags_out = f4_reg;
    assign x_out     = CW'(nx_reg);
    assign y_out     = CW'(ny_reg);
    assign power_out = power_reg;

endmodule

`default_nettype wire

// File: src/spbpc_iter.sv
`default_nettype none

module spbpc_iter #(
    parameter int SAMPLE_WIDTH = spbpc_pkg::DEF_SAMPLE_WIDTH,
    parameter int STEP         = 0
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      ce,
    input  wire spbpc_pkg::flags_t                         flags_in,
    input  wire logic signed [spbpc_pkg::CORDIC_WIDTH-1:0] x_in,
    input  wire logic signed [spbpc_pkg::CORDIC_WIDTH-1:0] y_in,
    input  wire logic [spbpc_pkg::ACC_WIDTH-1:0]           z_in,
    input  wire logic [SAMPLE_WIDTH+2:0]                   rem_in,
    input  wire logic [SAMPLE_WIDTH-1:0]                   root_in,
    input  wire logic [2*SAMPLE_WIDTH-1:0]                 power_in,
    output spbpc_pkg::flags_t                              flags_out,
    output logic signed [spbpc_pkg::CORDIC_WIDTH-1:0]      x_out,
    output logic signed [spbpc_pkg::CORDIC_WIDTH-1:0]      y_out,
    output logic [spbpc_pkg::ACC_WIDTH-1:0]                z_out,
    output logic [SAMPLE_WIDTH+2:0]                        rem_out,
    output logic [SAMPLE_WIDTH-1:0]                        root_out,
    output logic [2*SAMPLE_WIDTH-1:0]                      power_out
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int RW = SAMPLE_WIDTH + 3;
    localparam int CW = spbpc_pkg::CORDIC_WIDTH;
    localparam int ZW = spbpc_pkg::ACC_WIDTH;
    localparam logic [ZW-1:0] ATAN_STEP = spbpc_pkg::atan_entry(5'(STEP));

    spbpc_pkg::flags_t     flags_reg;
    logic signed [CW-1:0]  x_reg, x_next, y_reg, y_next;
    logic [ZW-1:0]         z_reg, z_next;
    logic [RW-1:0]         rem_reg, rem_next;
    logic [SW-1:0]         root_reg, root_next;
    logic [2*SW-1:0]       power_reg;

    // one vectoring rotation: drive y toward zero
    always_comb begin
        if (!y_in[CW-1]) begin
            x_next = x_in + (y_in >>> STEP);
            y_next = y_in - (x_in >>> STEP);
            z_next = z_in + ATAN_STEP;
        end else begin
            x_next = x_in - (y_in >>> STEP);
            y_next = y_in + (x_in >>> STEP);
            z_next = z_in - ATAN_STEP;
        end
    end

    // one digit of the restoring square root, two power bits per step
    if (STEP < SAMPLE_WIDTH) begin : g_sqrt
        localparam int K = SAMPLE_WIDTH - 1 - STEP;
        logic [RW-1:0] rem_sh, trial;

        always_comb begin
            rem_sh = {rem_in[RW-3:0], power_in[2*K+1 -: 2]};
            trial  = RW'({root_in, 2'b01});
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[SW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_in[SW-2:0], 1'b0};
            end
        end
    end else begin : g_pass
        always_comb begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg <= '0;
        end else if (ce) begin
            flags_reg <= flags_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            power_reg <= power_in;
        end
    end

    assign flags_out = flags_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign power_out = power_reg;

endmodule

`default_nettype wire

// File: src/spbpc_back.sv
`default_nettype none

module spbpc_back #(
    parameter int SAMPLE_WIDTH = spbpc_pkg::DEF_SAMPLE_WIDTH,
    parameter int ANGLE_WIDTH  = spbpc_pkg::DEF_ANGLE_WIDTH,
    localparam int M_DW = ((spbpc_pkg::POWER_WIDTH + spbpc_pkg::MAG_WIDTH + ANGLE_WIDTH + 7)
                           / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire spbpc_pkg::flags_t               flags_in,
    input  wire logic [spbpc_pkg::ACC_WIDTH-1:0] z_in,
    input  wire logic [SAMPLE_WIDTH-1:0]         root_in,
    input  wire logic [2*SAMPLE_WIDTH-1:0]       power_in,
    input  wire logic                            m_tready,
    output logic                                 m_tvalid,
    output logic [M_DW-1:0]                      m_tdata,
    output logic                                 m_tlast,
    output logic                                 ce
);

    localparam int ZW    = spbpc_pkg::ACC_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int PWR_W = spbpc_pkg::POWER_WIDTH;
    localparam int MAG_W = spbpc_pkg::MAG_WIDTH;

    logic [ZW-1:0]   z_oct, z_half, z_full, z_round;
    logic [AW-1:0]   phase;
    logic [M_DW-1:0] res_data;
    logic            res_valid, take;

    logic            out_valid_reg, out_valid_next, out_last_reg, out_last_next;
    logic [M_DW-1:0] out_data_reg, out_data_next;
    logic            skid_valid_reg, skid_valid_next, skid_last_reg, skid_last_next;
    logic [M_DW-1:0] skid_data_reg, skid_data_next;

    // unfold the octant angle and round to the output angle width
    always_comb begin
        z_oct   = flags_in.swapped ? ((ZW'(1) << (ZW - 2)) - z_in) : z_in;
        z_half  = flags_in.re_neg ? ((ZW'(1) << (ZW - 1)) - z_oct) : z_oct;
        z_full  = flags_in.im_neg ? (~z_half + 1'b1) : z_half;
        z_round = z_full + (ZW'(1) << (ZW - 1 - AW));
        phase   = flags_in.zero ? '0 : z_round[ZW-1 -: AW];
    end

    // result word: power, magnitude, phase from the lowest bit up
    assign res_data  = M_DW'({phase, MAG_W'(root_in), PWR_W'(power_in)});
    assign ce        = !skid_valid_reg;
    assign res_valid = ce && flags_in.valid;
    assign take      = out_valid_reg && m_tready;

    // output register with one skid entry behind it
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;
        priority if (skid_valid_reg) begin
            if (take || !out_valid_reg) begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                skid_valid_next = 1'b0;
            end
        end else if (res_valid) begin
            if (take || !out_valid_reg) begin
                out_valid_next = 1'b1;
                out_data_next  = res_data;
                out_last_next  = flags_in.last;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = res_data;
                skid_last_next  = flags_in.last;
            end
        end else if (take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: src/spectrum_bin_polar_converter_core.sv
// an accepted request runs through the front stages, the cordic/sqrt stages and the output register
// throughput: one request per cycle while s_tready is high; 4 front stages plus 32 cordic/sqrt stages
// s_tready drops only while the output skid entry holds a stalled result
// reset: synchronous active-low aresetn clears every valid bit; no clearing pass
`default_nettype none

module spectrum_bin_polar_converter_core #(
    parameter int SAMPLE_WIDTH = spbpc_pkg::DEF_SAMPLE_WIDTH,
    parameter int ANGLE_WIDTH  = spbpc_pkg::DEF_ANGLE_WIDTH,
    localparam int S_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_DW = ((spbpc_pkg::POWER_WIDTH + spbpc_pkg::MAG_WIDTH + ANGLE_WIDTH + 7)
                           / 8) * 8
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [S_DW-1:0] s_tdata,   // real_part, imag_part
    input  wire logic            s_tlast,   // bin_last
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [M_DW-1:0]      m_tdata,   // power, magnitude, phase
    output logic                 m_tlast    // result_last
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int CW    = spbpc_pkg::CORDIC_WIDTH;
    localparam int ZW    = spbpc_pkg::ACC_WIDTH;
    localparam int NSTEP = spbpc_pkg::CORDIC_STEPS;

    logic ce;

    spbpc_pkg::flags_t    flags_s [0:NSTEP];
    logic signed [CW-1:0] x_s     [0:NSTEP];
    logic signed [CW-1:0] y_s     [0:NSTEP];
    logic [ZW-1:0]        z_s     [0:NSTEP];
    logic [SW+2:0]        rem_s   [0:NSTEP];
    logic [SW-1:0]        root_s  [0:NSTEP];
    logic [2*SW-1:0]      power_s [0:NSTEP];

    assign s_tready = ce;

    // abs, squares, fold and normalization
    spbpc_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .real_part (s_tdata[SW-1:0]),
        .imag_part (s_tdata[2*SW-1:SW]),
        .flags_out (flags_s[0]),
        .x_out     (x_s[0]),
        .y_out     (y_s[0]),
        .power_out (power_s[0])
    );

    assign z_s[0]    = '0;
    assign rem_s[0]  = '0;
    assign root_s[0] = '0;

    // cordic rotations with square-root digits alongside
    for (genvar g = 0; g < NSTEP; g++) begin : g_iter
        spbpc_iter #(
            .SAMPLE_WIDTH(SAMPLE_WIDTH),
            .STEP        (g)
        ) u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ce        (ce),
            .flags_in  (flags_s[g]),
            .x_in      (x_s[g]),
            .y_in      (y_s[g]),
            .z_in      (z_s[g]),
            .rem_in    (rem_s[g]),
            .root_in   (root_s[g]),
            .power_in  (power_s[g]),
            .flags_out (flags_s[g+1]),
            .x_out     (x_s[g+1]),
            .y_out     (y_s[g+1]),
            .z_out     (z_s[g+1]),
            .rem_out   (rem_s[g+1]),
            .root_out  (root_s[g+1]),
            .power_out (power_s[g+1])
        );
    end

    // angle unfold, rounding and output buffering
    spbpc_back #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .flags_in (flags_s[NSTEP]),
        .z_in     (z_s[NSTEP]),
        .root_in  (root_s[NSTEP]),
        .power_in (power_s[NSTEP]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .ce       (ce)
    );

endmodule

`default_nettype wire

// File: src/spbpc_checker.sv
`default_nettype none
`include "assert_macros.svh"

module spbpc_checker #(
    parameter int SAMPLE_WIDTH = spbpc_pkg::DEF_SAMPLE_WIDTH,
    parameter int ANGLE_WIDTH  = spbpc_pkg::DEF_ANGLE_WIDTH,
    localparam int S_DW = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int M_DW = ((spbpc_pkg::POWER_WIDTH + spbpc_pkg::MAG_WIDTH + ANGLE_WIDTH + 7)
                           / 8) * 8
) (
    input wire logic            aclk,
    input wire logic            aresetn,
    input wire logic            s_tvalid,
    input wire logic            s_tready,
    input wire logic [S_DW-1:0] s_tdata,
    input wire logic            s_tlast,
    input wire logic            m_tvalid,
    input wire logic            m_tready,
    input wire logic [M_DW-1:0] m_tdata,
    input wire logic            m_tlast
);

    // a stalled result holds its word and flag
    `SPBPC_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

    // reset empties the output and opens the input
    `SPBPC_ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid && s_tready, "reset did not clear output")

    // input is closed only while a result is pending
    `SPBPC_ASSERT(a_ready_pending, aclk, aresetn, !s_tready |-> m_tvalid, "ready low with no result pending")

    // ready falls only after a stalled result
    `SPBPC_ASSERT(a_ready_fall, aclk, aresetn, $fell(s_tready) |-> $past(m_tvalid && !m_tready), "ready fell without a stall")

endmodule

bind spectrum_bin_polar_converter_core spbpc_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH)
) u_spbpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// File: tb/sv/spectrum_bin_polar_converter_core_tb.sv
`default_nettype none

module spectrum_bin_polar_converter_core_tb;

    localparam int SW   = spbpc_pkg::DEF_SAMPLE_WIDTH;
    localparam int AW   = spbpc_pkg::DEF_ANGLE_WIDTH;
    localparam int PW   = spbpc_pkg::POWER_WIDTH;
    localparam int MW   = spbpc_pkg::MAG_WIDTH;
    localparam int S_DW = ((2 * SW + 7) / 8) * 8;
    localparam int M_DW = ((PW + MW + AW + 7) / 8) * 8;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int REPORT_MAX   = 10;

    // rotation angles atan(2^-i), 2^32 counts per full turn
    localparam logic [31:0] ROT_ANGLE [32] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    // corner bins: origin, both axes, full-scale corners, unit steps, 3-4-5
    localparam int CORNER_RE [22] = '{
        0, -8388608, 8388607, 0, 0, -8388608, 8388607, -8388608, 8388607, 1, 0,
        -1, 0, 1, -1, 1, -1, 3, -8388608, 1, -5, 0
    };
    localparam int CORNER_IM [22] = '{
        0, 0, 0, 8388607, -8388608, -8388608, 8388607, 8388607, -8388608, 0, 1,
        0, -1, 1, -1, -1, 1, 4, 1, -8388608, 0, -7
    };

    typedef struct packed {
        logic [PW-1:0]        power;
        logic [MW-1:0]        magnitude;
        logic signed [AW-1:0] phase;
        logic                 last;
    } polar_result_t;

    typedef enum {BIN_FULL, BIN_SMALL, BIN_AXIS, BIN_DIAG, BIN_SKEW} bin_kind_t;
    typedef enum {RX_STREAM, RX_COIN, RX_CHOKE, RX_BEAT} rx_mode_t;

    // expected polar results, oldest first
    class polar_scoreboard;
        polar_result_t pending[$];
        int            mismatch_count;
        int            checked_count;

        function new();
            mismatch_count = 0;
            checked_count  = 0;
        endfunction

        function longint unsigned floor_sqrt(longint unsigned p);
            longint unsigned root;
            longint unsigned probe;
            root  = 0;
            probe = 64'h1 << 62;
            while (probe > p)
                probe = probe >> 2;
            while (probe != 0) begin
                if (p >= root + probe) begin
                    p    = p - (root + probe);
                    root = (root >> 1) + probe;
                end else begin
                    root = root >> 1;
                end
                probe = probe >> 2;
            end
            return root;
        endfunction

        // vectoring rotation in the first octant, then unfold to the full circle
        function logic [AW-1:0] binary_angle(longint re, longint im);
            longint          ax, ay, x, y, z, xs, ys, t;
            bit              swapped;
            longint unsigned u;
            ax      = (re < 0) ? -re : re;
            ay      = (im < 0) ? -im : im;
            z       = 0;
            swapped = 1'b0;
            if (ax == 0 && ay == 0)
                return '0;
            if (ay > ax) begin
                t       = ax;
                ax      = ay;
                ay      = t;
                swapped = 1'b1;
            end
            x = ax;
            y = ay;
            while (x < (64'sd1 <<< 60)) begin
                x = x * 2;
                y = y * 2;
            end
            for (int i = 0; i < 32; i++) begin
                xs = y >>> i;
                ys = x >>> i;
                if (y >= 0) begin
                    x = x + xs;
                    y = y - ys;
                    z = z + longint'(ROT_ANGLE[i]);
                end else begin
                    x = x - xs;
                    y = y + ys;
                    z = z - longint'(ROT_ANGLE[i]);
                end
            end
            if (swapped)
                z = (64'sd1 <<< 30) - z;
            if (re < 0)
                z = (64'sd1 <<< 31) - z;
            if (im < 0)
                z = -z;
            u = longint'(z) + (64'd1 << (31 - AW));
            u = u >> (32 - AW);
            return u[AW-1:0];
        endfunction

        function void note_request(logic signed [SW-1:0] re, logic signed [SW-1:0] im,
                                   logic last);
            polar_result_t   want;
            longint          r, i;
            longint unsigned pw;
            r              = re;
            i              = im;
            pw             = longint'(r * r) + longint'(i * i);
            want.power     = pw[PW-1:0];
            want.magnitude = MW'(floor_sqrt(pw));
            want.phase     = binary_angle(r, i);
            want.last      = last;
            pending.push_back(want);
        endfunction

        function void check_result(logic [M_DW-1:0] data, logic last);
            polar_result_t got, want;
            got.power     = data[PW-1:0];
            got.magnitude = data[PW+MW-1:PW];
            got.phase     = data[PW+MW+AW-1:PW+MW];
            got.last      = last;
            if (pending.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("result with no request pending: power %0d mag %0d phase %0d",
                             got.power, got.magnitude, got.phase);
                return;
            end
            want = pending.pop_front();
            checked_count++;
            if (got != want) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("mismatch on result %0d: power %0d/%0d mag %0d/%0d phase %0d/%0d last %0b/%0b (exp/got)",
                             checked_count, want.power, got.power, want.magnitude,
                             got.magnitude, want.phase, got.phase, want.last, got.last);
            end
        endfunction
    endclass

    logic            aclk;
    logic            aresetn  = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [S_DW-1:0] s_tdata  = '0;
    logic            s_tlast  = 1'b0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [M_DW-1:0] m_tdata;
    logic            m_tlast;

    polar_scoreboard sb = new();

    int       cycle_count   = 0;
    int       request_count = 0;
    int       frame_count   = 0;
    int       frame_left    = 0;
    int       rx_left       = 0;
    int       rx_tick       = 0;
    rx_mode_t rx_mode       = RX_STREAM;

    spectrum_bin_polar_converter_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL spectrum_bin_polar_converter_core");
            $finish;
        end
    end

    // receiver backpressure, switching between stall patterns
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 200);
        end
        rx_left--;
        rx_tick++;
        case (rx_mode)
            RX_STREAM: m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
            RX_CHOKE:  m_tready <= ($urandom_range(0, 3) == 0);
            default:   m_tready <= (rx_tick % 5 != 0);
        endcase
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // one request, called at a falling edge, returns at the falling edge after acceptance
    task automatic send_bin(logic signed [SW-1:0] re, logic signed [SW-1:0] im, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= S_DW'({im, re});
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(re, im, last);
        request_count++;
        if (last)
            frame_count++;
        @(negedge aclk);
    endtask

    task automatic idle_for(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge aclk);
    endtask

    // random bin, biased toward axes, diagonals and lopsided pairs
    task automatic pick_bin(output logic signed [SW-1:0] re, output logic signed [SW-1:0] im);
        bin_kind_t kind;
        logic [31:0] a, b;
        kind = bin_kind_t'($urandom_range(0, 4));
        a    = $urandom();
        b    = $urandom();
        case (kind)
            BIN_FULL: begin
                re = a[SW-1:0];
                im = b[SW-1:0];
            end
            BIN_SMALL: begin
                re = SW'(int'($urandom_range(0, 32)) - 16);
                im = SW'(int'($urandom_range(0, 32)) - 16);
            end
            BIN_AXIS: begin
                re = b[0] ? a[SW-1:0] : '0;
                im = b[0] ? '0 : a[SW-1:0];
            end
            BIN_DIAG: begin
                re = a[SW-1:0];
                im = b[0] ? -a[SW-1:0] : a[SW-1:0];
            end
            default: begin
                re = b[1] ? a[SW-1:0] : SW'(int'($urandom_range(0, 64)) - 32);
                im = b[1] ? SW'(int'($urandom_range(0, 64)) - 32) : a[SW-1:0];
            end
        endcase
    endtask

    // bursts of requests split into spectrum frames, random gaps between bursts
    task automatic run_random(int count);
        int sent, burst, gap;
        logic signed [SW-1:0] re, im;
        logic last;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                if (frame_left == 0)
                    frame_left = $urandom_range(1, 64);
                frame_left--;
                last = (frame_left == 0);
                pick_bin(re, im);
                send_bin(re, im, last);
                sent++;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                9:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap != 0)
                idle_for(gap);
        end
    endtask

    // stimulus
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // corner bins back to back
        foreach (CORNER_RE[k])
            send_bin(SW'(CORNER_RE[k]), SW'(CORNER_IM[k]), (k % 7 == 6) || (k == 21));
        idle_for(3);

        run_random(850);

        // let the pipeline empty completely before resuming
        wait_drained();
        idle_for($urandom_range(1, 10));

        run_random(900);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("covered %0d bins in %0d spectrum frames: origin, axes, diagonals, full scale",
                 request_count, frame_count);
        $display("results checked %0d, with sender bursts and four receiver stall patterns",
                 sb.checked_count);
        if (sb.mismatch_count == 0 && sb.pending.size() == 0) begin
            $display("PASS spectrum_bin_polar_converter_core");
        end else begin
            $display("%0d mismatches", sb.mismatch_count);
            $display("FAIL spectrum_bin_polar_converter_core");
        end
        $finish;
    end

endmodule

`default_nettype wire
